// File: hdl/rlpd_pkg.sv
// Shared types and codes for the recursive-length-prefix stream decoder.
// No dependencies; imported by rlpd_stack and rlp_stream_decoder_unit.
`default_nettype none
package rlpd_pkg;

    localparam int unsigned MaxDepthDef = 8;

    // Byte thresholds of the prefix ranges
    localparam logic [7:0] LongListBase = 8'hf7;
    localparam logic [7:0] LongListMin  = 8'hf8;
    localparam logic [7:0] ShortListMin = 8'hc0;
    localparam logic [7:0] LongStrMin   = 8'hb8;
    localparam logic [7:0] LongStrBase  = 8'hb7;
    localparam logic [7:0] ShortStrMin  = 8'h80;

    localparam logic [2:0] ROLE_LIST    = 3'd0;
    localparam logic [2:0] ROLE_STRING  = 3'd1;
    localparam logic [2:0] ROLE_LENGTH  = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_SINGLE  = 3'd4;
    localparam logic [2:0] ROLE_TRAIL   = 3'd5;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_LENLEN  = 3'd1;
    localparam logic [2:0] ERR_TRUNC   = 3'd2;
    localparam logic [2:0] ERR_OVERRUN = 3'd3;
    localparam logic [2:0] ERR_DEEP    = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  role;
        logic [3:0]  depth;
        logic [15:0] item_length;
        logic        header_done;
        logic [3:0]  items_closed;
        logic        top_done;
        logic [2:0]  error_code;
        logic        message_ok;
    } t_out_beat;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_TRAILING,
        PH_HALTED
    } t_phase;

    typedef enum logic {
        FS_IDLE,
        FS_POP
    } t_fsm;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_stk_ctl;

endpackage
`default_nettype wire

// File: hdl/rlp_stream_decoder_unit.sv
// Recursive-length-prefix stream decoder, one byte per beat; uses rlpd_pkg, rlpd_stack.
// The result is registered; one byte per cycle while no list pop runs and i_stall does not hold the output.
// A byte that closes the innermost list holds the input while the stack is read for each
// further list it closes, and once more to reload the new innermost end when a
// list stays open.
// Reset: synchronous, active low; clears all control state, no clearing pass.
`default_nettype none
module rlp_stream_decoder_unit
    import rlpd_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = MaxDepthDef
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_beat  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_beat      o_data
);
    localparam int unsigned AddrW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned OpenW = $clog2(MAX_DEPTH + 1);
    localparam logic [OpenW-1:0] OpenMax = OpenW'(MAX_DEPTH);

    t_fsm             r_fsm, n_fsm;
    t_phase           r_phase, n_phase;
    logic [OpenW-1:0] r_open, n_open;
    logic [15:0]      r_top_end, n_top_end;
    logic [15:0]      r_pos, n_pos;
    logic [1:0]       r_lenleft, n_lenleft;
    logic [15:0]      r_accum, n_accum;
    logic [15:0]      r_strrem, n_strrem;
    logic             r_islist, n_islist;
    logic [2:0]       r_err, n_err;
    logic             r_last, n_last;
    t_out_beat        r_w, n_w;
    t_out_beat        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             in_acc;
    logic             go_pop;
    logic             pop_end;
    logic             done;
    t_stk_ctl         stk_ctl;
    logic [AddrW-1:0] stk_rd_addr;
    logic [15:0]      stk_wr_data;
    logic [15:0]      stk_rd_data;

    logic [7:0]       b;
    logic [15:0]      room;
    logic [3:0]       ll;
    logic             fh_do;
    logic             fh_list;
    logic [15:0]      fh_len;
    logic             id_do;
    logic             consume;

    assign o_stall = (r_fsm != FS_IDLE) || (r_out_valid && i_stall);
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    rlpd_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_ctl     (stk_ctl),
        .i_wr_addr (r_open[AddrW-1:0]),
        .i_wr_data (stk_wr_data),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

    // Next state of the sequencer
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            FS_IDLE: begin
                if (go_pop) begin
                    n_fsm = FS_POP;
                end
            end
            FS_POP: begin
                if (pop_end) begin
                    n_fsm = FS_IDLE;
                end
            end
            default: n_fsm = FS_IDLE;
        endcase
    end

    // Decode datapath: classify the byte, update the stack, close items
    always_comb begin
        n_phase     = r_phase;
        n_open      = r_open;
        n_top_end   = r_top_end;
        n_pos       = r_pos;
        n_lenleft   = r_lenleft;
        n_accum     = r_accum;
        n_strrem    = r_strrem;
        n_islist    = r_islist;
        n_err       = r_err;
        n_last      = r_last;
        n_w         = r_w;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        go_pop      = 1'b0;
        pop_end     = 1'b0;
        done        = 1'b0;
        stk_ctl     = '0;
        stk_rd_addr = '0;
        stk_wr_data = '0;
        b           = i_data.in_byte;
        consume     = 1'b0;
        room        = '0;
        ll          = '0;
        fh_do       = 1'b0;
        fh_list     = 1'b0;
        fh_len      = '0;
        id_do       = 1'b0;

        case (r_fsm)
            FS_IDLE: begin
                if (in_acc) begin
                    n_last           = i_data.msg_last;
                    n_w              = '0;
                    n_w.byte_value   = b;
                    n_w.role         = ROLE_TRAIL;
                    n_w.depth        = 4'(r_open);
                    consume = (r_phase == PH_PREFIX) || (r_phase == PH_LENGTH)
                              || (r_phase == PH_PAYLOAD);
                    n_pos = r_pos + 16'(consume);
                    room  = r_top_end - n_pos;

                    case (r_phase)
                        PH_PREFIX: begin
                            if ((b >= LongListMin)
                                || ((b >= LongStrMin) && (b < ShortListMin))) begin
                                fh_list    = (b >= ShortListMin);
                                ll         = fh_list ? 4'(b - LongListBase) : 4'(b - LongStrBase);
                                n_w.role   = fh_list ? ROLE_LIST : ROLE_STRING;
                                if (ll > 4'd2) begin
                                    if (n_err == ERR_NONE) n_err = ERR_LENLEN;
                                    n_phase = PH_HALTED;
                                end else if ((r_open != '0) && (room < 16'(ll))) begin
                                    if (n_err == ERR_NONE) n_err = ERR_OVERRUN;
                                    n_phase = PH_HALTED;
                                end else begin
                                    n_lenleft = ll[1:0];
                                    n_accum   = '0;
                                    n_islist  = fh_list;
                                    n_phase   = PH_LENGTH;
                                end
                            end else if (b >= ShortListMin) begin
                                n_w.role = ROLE_LIST;
                                fh_do    = 1'b1;
                                fh_list  = 1'b1;
                                fh_len   = 16'(b - ShortListMin);
                            end else if (b >= ShortStrMin) begin
                                n_w.role = ROLE_STRING;
                                fh_do    = 1'b1;
                                fh_len   = 16'(b - ShortStrMin);
                            end else begin
                                n_w.role = ROLE_SINGLE;
                                id_do    = 1'b1;
                            end
                        end
                        PH_LENGTH: begin
                            n_w.role = ROLE_LENGTH;
                            n_accum  = {r_accum[7:0], b};
                            if (r_lenleft != 2'd0) n_lenleft = r_lenleft - 2'd1;
                            if (n_lenleft == 2'd0) begin
                                fh_do   = 1'b1;
                                fh_list = r_islist;
                                fh_len  = n_accum;
                            end
                        end
                        PH_PAYLOAD: begin
                            n_w.role = ROLE_PAYLOAD;
                            if (r_strrem != 16'd0) n_strrem = r_strrem - 16'd1;
                            if (n_strrem == 16'd0) id_do = 1'b1;
                        end
                        default: begin
                            n_w.depth = 4'd0;
                        end
                    endcase

                    // Finish a header: check room and depth, then close an empty item, open a list or start a string
                    if (fh_do) begin
                        n_w.header_done = 1'b1;
                        n_w.item_length = fh_len;
                        if ((r_open != '0) && (fh_len > room)) begin
                            if (n_err == ERR_NONE) n_err = ERR_OVERRUN;
                            n_phase = PH_HALTED;
                        end else if (fh_len == 16'd0) begin
                            id_do = 1'b1;
                        end else if (fh_list) begin
                            if (r_open >= OpenMax) begin
                                if (n_err == ERR_NONE) n_err = ERR_DEEP;
                                n_phase = PH_HALTED;
                            end else begin
                                stk_ctl.wr_en = 1'b1;
                                stk_wr_data   = n_pos + fh_len;
                                n_top_end     = n_pos + fh_len;
                                n_open        = r_open + 1'b1;
                                n_phase       = PH_PREFIX;
                            end
                        end else begin
                            n_strrem = fh_len;
                            n_phase  = PH_PAYLOAD;
                        end
                    end

                    // Close the item, and the innermost list if it is used up
                    if (id_do) begin
                        n_w.items_closed = 4'd1;
                        n_phase          = PH_PREFIX;
                        if ((r_open != '0) && (room == 16'd0)) begin
                            n_open           = r_open - 1'b1;
                            n_w.items_closed = 4'd2;
                            if (n_open != '0) begin
                                go_pop        = 1'b1;
                                stk_ctl.rd_en = 1'b1;
                                stk_rd_addr   = AddrW'(n_open - 1'b1);
                            end
                        end
                        if (n_open == '0) begin
                            n_w.top_done = 1'b1;
                            n_phase      = PH_TRAILING;
                        end
                    end
                    done = !go_pop;
                end
            end
            FS_POP: begin
                // Walk outward while enclosing lists end at this byte
                if (stk_rd_data == r_pos) begin
                    n_open           = r_open - 1'b1;
                    n_w.items_closed = r_w.items_closed + 4'd1;
                    if (n_open != '0) begin
                        stk_ctl.rd_en = 1'b1;
                        stk_rd_addr   = AddrW'(n_open - 1'b1);
                    end else begin
                        n_w.top_done = 1'b1;
                        n_phase      = PH_TRAILING;
                        pop_end      = 1'b1;
                    end
                end else begin
                    n_top_end = stk_rd_data;
                    pop_end   = 1'b1;
                end
                done = pop_end;
            end
            default: begin
                done = 1'b0;
            end
        endcase

        // Emit the beat; at message end check truncation and reset state
        if (done) begin
            n_out            = n_w;
            n_out.message_ok = 1'b0;
            if (n_last) begin
                if ((n_err == ERR_NONE) && (n_phase != PH_TRAILING)) begin
                    n_err = ERR_TRUNC;
                end
                n_out.message_ok = (n_err == ERR_NONE);
            end
            n_out.error_code = n_err;
            n_out_valid      = 1'b1;
            if (n_last) begin
                n_phase   = PH_PREFIX;
                n_open    = '0;
                n_lenleft = '0;
                n_accum   = '0;
                n_strrem  = '0;
                n_islist  = 1'b0;
                n_err     = ERR_NONE;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= FS_IDLE;
            r_phase     <= PH_PREFIX;
            r_open      <= '0;
            r_pos       <= '0;
            r_lenleft   <= '0;
            r_accum     <= '0;
            r_strrem    <= '0;
            r_islist    <= 1'b0;
            r_err       <= ERR_NONE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_phase     <= n_phase;
            r_open      <= n_open;
            r_pos       <= n_pos;
            r_lenleft   <= n_lenleft;
            r_accum     <= n_accum;
            r_strrem    <= n_strrem;
            r_islist    <= n_islist;
            r_err       <= n_err;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top_end <= n_top_end;
        r_w       <= n_w;
        r_out     <= n_out;
    end
endmodule
`default_nettype wire

// File: hdl/rlpd_stack.sv
// Stack of list end positions, one entry per open list.
// Depends on rlpd_pkg for the port control struct.
`default_nettype none
module rlpd_stack
    import rlpd_pkg::*;
#(
    parameter  int unsigned MAX_DEPTH = MaxDepthDef,
    localparam int unsigned AddrW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire t_stk_ctl               i_ctl,
    input  wire logic [AddrW-1:0]       i_wr_addr,
    input  wire logic [15:0]            i_wr_data,
    input  wire logic [AddrW-1:0]       i_rd_addr,
    output logic [15:0]                 o_rd_data
);
    logic [15:0] r_mem [MAX_DEPTH];
    logic [15:0] r_rd_data;

    // Write one entry, read one entry with a registered result
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire
